// File: sv/cfrc_pkg.sv
// shared types, codes and constants for the chunked frame reassembly checker
package cfrc_pkg;

  localparam int CNT_BITS_DEF = 32;
  localparam int Q_DEPTH      = 2;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_TDATA_W   = 184;
  localparam int OUT_TDATA_W  = 200;

  // result bus layout, lowest bit first
  localparam int OUT_ROUTE_LSB = 4;
  localparam int OUT_OFF_LSB   = 6;
  localparam int OUT_TOT_LSB   = 38;

  typedef enum logic [3:0] {
    V_FORWARD   = 4'd0,
    V_SHORT     = 4'd1,
    V_HEADER    = 4'd2,
    V_SIZE      = 4'd3,
    V_CRC       = 4'd4,
    V_START_POS = 4'd5,
    V_START_TOT = 4'd6,
    V_UNROUTED  = 4'd7,
    V_CHANGED   = 4'd8,
    V_ORDER     = 4'd9,
    V_OVERRUN   = 4'd10,
    V_END_SHORT = 4'd11,
    V_NO_END    = 4'd12
  } verdict_t;

  localparam logic [1:0] ROUTE_NONE   = 2'd0;
  localparam logic [1:0] ROUTE_FILE   = 2'd1;
  localparam logic [1:0] ROUTE_STREAM = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_VERSION    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HDR_SIZE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_MASK = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_END_MASK   = 3'd5;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] expected_header_size;
    logic [15:0] payload_limit;
    logic [31:0] frame_limit;
    logic [7:0]  start_mask;
    logic [7:0]  end_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  version_byte;
    logic [7:0]  flag_bits;
    logic [15:0] declared_header_size;
    logic [31:0] sequence_number;
    logic [31:0] frame_size;
    logic [31:0] byte_offset;
    logic [15:0] payload_length;
    logic [15:0] chunk_number;
    logic [15:0] slot_length;
    logic        crc_match;
    logic        file_busy;
    logic        stream_busy;
  } slot_t;

  // classified slot handed from front to back
  typedef struct packed {
    verdict_t    pre_verdict;
    logic        start_hit;
    logic        is_end;
    logic [1:0]  route;
    logic [31:0] sequence_number;
    logic [31:0] frame_size;
    logic [31:0] byte_offset;
    logic [15:0] chunk_number;
    logic [32:0] reach;
  } item_t;

  typedef struct packed {
    logic [31:0] unrouted_count;
    logic [31:0] dropped_frames;
    logic [31:0] good_frames;
    logic [31:0] slot_count;
    logic [31:0] chunk_total;
    logic [31:0] chunk_offset;
    logic [1:0]  route;
    verdict_t    verdict;
    logic        last_chunk;
  } res_t;

endpackage

// File: sv/cfrc_regs.sv
// configuration register bank of the reassembly checker
module cfrc_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cfrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output cfrc_pkg::cfg_t                    cfg
);

  cfrc_pkg::cfg_t cfg_r;
  cfrc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        cfrc_pkg::REG_VERSION:    cfg_nxt.expected_version     = cfg_wdata[7:0];
        cfrc_pkg::REG_HDR_SIZE:   cfg_nxt.expected_header_size = cfg_wdata[15:0];
        cfrc_pkg::REG_PAYLOAD:    cfg_nxt.payload_limit        = cfg_wdata[15:0];
        cfrc_pkg::REG_FRAME:      cfg_nxt.frame_limit          = cfg_wdata[31:0];
        cfrc_pkg::REG_START_MASK: cfg_nxt.start_mask           = cfg_wdata[7:0];
        cfrc_pkg::REG_END_MASK:   cfg_nxt.end_mask             = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_version     <= 8'd1;
      cfg_r.expected_header_size <= 16'd32;
      cfg_r.payload_limit        <= 16'd4096;
      cfg_r.frame_limit          <= 32'd65536;
      cfg_r.start_mask           <= 8'd1;
      cfg_r.end_mask             <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/cfrc_front.sv
// front end: stateless slot checks and start-of-frame classification
module cfrc_front (
  input  cfrc_pkg::cfg_t  cfg,
  input  cfrc_pkg::slot_t slot,
  output cfrc_pkg::item_t item
);

  logic        short_slot;
  logic        bad_header;
  logic        bad_payload;
  logic        start_hit;
  logic [16:0] need_len;
  logic [1:0]  dest;

  assign short_slot = slot.slot_length < cfg.expected_header_size;
  assign bad_header = (slot.version_byte != cfg.expected_version) ||
                      (slot.declared_header_size != cfg.expected_header_size);
  assign need_len   = {1'b0, cfg.expected_header_size} + {1'b0, slot.payload_length};
  assign bad_payload = (slot.payload_length == 16'd0) ||
                       (slot.payload_length > cfg.payload_limit) ||
                       (need_len > {1'b0, slot.slot_length});
  assign start_hit = |(slot.flag_bits & cfg.start_mask);

  // file session takes priority over the stream session
  assign dest = slot.file_busy   ? cfrc_pkg::ROUTE_FILE   :
                slot.stream_busy ? cfrc_pkg::ROUTE_STREAM : cfrc_pkg::ROUTE_NONE;

  always_comb begin
    item.start_hit       = start_hit;
    item.is_end          = |(slot.flag_bits & cfg.end_mask);
    item.route           = dest;
    item.sequence_number = slot.sequence_number;
    item.frame_size      = slot.frame_size;
    item.byte_offset     = slot.byte_offset;
    item.chunk_number    = slot.chunk_number;
    item.reach           = {1'b0, slot.byte_offset} + {17'd0, slot.payload_length};
    if (short_slot) begin
      item.pre_verdict = cfrc_pkg::V_SHORT;
    end else if (bad_header) begin
      item.pre_verdict = cfrc_pkg::V_HEADER;
    end else if (bad_payload) begin
      item.pre_verdict = cfrc_pkg::V_SIZE;
    end else if (!slot.crc_match) begin
      item.pre_verdict = cfrc_pkg::V_CRC;
    end else if (start_hit &&
                 (slot.byte_offset != 32'd0 || slot.chunk_number != 16'd0)) begin
      item.pre_verdict = cfrc_pkg::V_START_POS;
    end else if (start_hit &&
                 (slot.frame_size == 32'd0 || slot.frame_size > cfg.frame_limit)) begin
      item.pre_verdict = cfrc_pkg::V_START_TOT;
    end else if (start_hit && dest == cfrc_pkg::ROUTE_NONE) begin
      item.pre_verdict = cfrc_pkg::V_UNROUTED;
    end else begin
      item.pre_verdict = cfrc_pkg::V_FORWARD;
    end
  end

endmodule

// File: sv/cfrc_queue.sv
// short queue between front and back
module cfrc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  cfrc_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output cfrc_pkg::item_t rd_item
);

  localparam int PTR_W = (cfrc_pkg::Q_DEPTH > 1) ? $clog2(cfrc_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(cfrc_pkg::Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(cfrc_pkg::Q_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(cfrc_pkg::Q_DEPTH - 1);

  cfrc_pkg::item_t   mem [cfrc_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ready_r, ready_nxt;
  logic              push, pop;

  assign push = wr_valid && ready_r;
  assign pop  = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
    ready_nxt = count_nxt != FULL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      ready_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      ready_r  <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  assign wr_ready = ready_r;
  assign rd_valid = count_r != '0;
  assign rd_item  = mem[rd_ptr_r];

endmodule

// File: sv/cfrc_back.sv
// back end: open-frame tracking, counters and the result register
module cfrc_back #(
  parameter int COUNTER_BITS = cfrc_pkg::CNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  cfrc_pkg::item_t q_item,
  output logic            res_valid,
  input  logic            res_ready,
  output cfrc_pkg::res_t  res
);

  localparam int CB = COUNTER_BITS;

  // frame state
  logic        open_r, open_nxt;
  logic [1:0]  route_r, route_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] exp_off_r, exp_off_nxt;
  logic [15:0] exp_chunk_r, exp_chunk_nxt;

  // counters
  logic [CB-1:0] slots_r, slots_nxt;
  logic [CB-1:0] good_r, good_nxt;
  logic [CB-1:0] drop_r, drop_nxt;
  logic [CB-1:0] unr_r, unr_nxt;

  // result register
  logic              valid_r, valid_nxt;
  cfrc_pkg::verdict_t verdict_r, verdict_nxt;
  logic [1:0]        o_route_r, o_route_nxt;
  logic [31:0]       o_off_r, o_off_nxt;
  logic [31:0]       o_tot_r, o_tot_nxt;
  logic              o_last_r, o_last_nxt;

  logic        pop;
  logic        open_eff;
  logic [1:0]  route_eff;
  logic [31:0] seq_eff, tot_eff, off_eff;
  logic [15:0] chunk_eff;
  logic [1:0]  drop_inc;
  cfrc_pkg::verdict_t v;

  assign q_ready = !valid_r || res_ready;
  assign pop     = q_valid && q_ready;

  // a start slot sees its own header as the open frame
  assign open_eff  = q_item.start_hit || open_r;
  assign route_eff = q_item.start_hit ? q_item.route : route_r;
  assign seq_eff   = q_item.start_hit ? q_item.sequence_number : seq_r;
  assign tot_eff   = q_item.start_hit ? q_item.frame_size : total_r;
  assign off_eff   = q_item.start_hit ? 32'd0 : exp_off_r;
  assign chunk_eff = q_item.start_hit ? 16'd0 : exp_chunk_r;

  always_comb begin
    if (q_item.sequence_number != seq_eff || q_item.frame_size != tot_eff) begin
      v = cfrc_pkg::V_CHANGED;
    end else if (q_item.byte_offset != off_eff || q_item.chunk_number != chunk_eff) begin
      v = cfrc_pkg::V_ORDER;
    end else if (q_item.reach > {1'b0, tot_eff}) begin
      v = cfrc_pkg::V_OVERRUN;
    end else if (q_item.is_end && q_item.reach != {1'b0, tot_eff}) begin
      v = cfrc_pkg::V_END_SHORT;
    end else if (!q_item.is_end && q_item.reach == {1'b0, tot_eff}) begin
      v = cfrc_pkg::V_NO_END;
    end else begin
      v = cfrc_pkg::V_FORWARD;
    end
  end

  always_comb begin
    open_nxt      = open_r;
    route_nxt     = route_r;
    seq_nxt       = seq_r;
    total_nxt     = total_r;
    exp_off_nxt   = exp_off_r;
    exp_chunk_nxt = exp_chunk_r;
    slots_nxt     = slots_r;
    good_nxt      = good_r;
    drop_nxt      = drop_r;
    unr_nxt       = unr_r;
    verdict_nxt   = verdict_r;
    o_route_nxt   = o_route_r;
    o_off_nxt     = o_off_r;
    o_tot_nxt     = o_tot_r;
    o_last_nxt    = o_last_r;
    drop_inc      = 2'd0;
    valid_nxt     = res_ready ? 1'b0 : valid_r;

    if (pop) begin
      valid_nxt   = 1'b1;
      verdict_nxt = q_item.pre_verdict;
      o_route_nxt = cfrc_pkg::ROUTE_NONE;
      o_off_nxt   = 32'd0;
      o_tot_nxt   = 32'd0;
      o_last_nxt  = 1'b0;
      if (q_item.pre_verdict != cfrc_pkg::V_SHORT) begin
        slots_nxt = slots_r + CB'(1);
      end
      if (q_item.pre_verdict == cfrc_pkg::V_FORWARD) begin
        if (!open_eff) begin
          // orphan slot
          verdict_nxt = cfrc_pkg::V_UNROUTED;
          unr_nxt     = unr_r + CB'(1);
        end else begin
          drop_inc    = {1'b0, q_item.start_hit && open_r};
          verdict_nxt = v;
          if (v == cfrc_pkg::V_FORWARD) begin
            o_route_nxt   = route_eff;
            o_off_nxt     = off_eff;
            o_tot_nxt     = tot_eff;
            o_last_nxt    = q_item.is_end;
            open_nxt      = 1'b1;
            route_nxt     = route_eff;
            seq_nxt       = seq_eff;
            total_nxt     = tot_eff;
            exp_off_nxt   = q_item.reach[31:0];
            exp_chunk_nxt = chunk_eff + 16'd1;
            if (q_item.is_end) begin
              good_nxt = good_r + CB'(1);
            end
          end else begin
            drop_inc = drop_inc + 2'd1;
          end
          if (v != cfrc_pkg::V_FORWARD || q_item.is_end) begin
            open_nxt      = 1'b0;
            route_nxt     = cfrc_pkg::ROUTE_NONE;
            seq_nxt       = 32'd0;
            total_nxt     = 32'd0;
            exp_off_nxt   = 32'd0;
            exp_chunk_nxt = 16'd0;
          end
        end
      end else if (q_item.pre_verdict != cfrc_pkg::V_SHORT) begin
        drop_inc      = {1'b0, open_r};
        open_nxt      = 1'b0;
        route_nxt     = cfrc_pkg::ROUTE_NONE;
        seq_nxt       = 32'd0;
        total_nxt     = 32'd0;
        exp_off_nxt   = 32'd0;
        exp_chunk_nxt = 16'd0;
        if (q_item.pre_verdict == cfrc_pkg::V_UNROUTED) begin
          unr_nxt = unr_r + CB'(1);
        end
      end
      drop_nxt = drop_r + CB'(drop_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      route_r     <= cfrc_pkg::ROUTE_NONE;
      seq_r       <= '0;
      total_r     <= '0;
      exp_off_r   <= '0;
      exp_chunk_r <= '0;
      slots_r     <= '0;
      good_r      <= '0;
      drop_r      <= '0;
      unr_r       <= '0;
      valid_r     <= 1'b0;
    end else begin
      open_r      <= open_nxt;
      route_r     <= route_nxt;
      seq_r       <= seq_nxt;
      total_r     <= total_nxt;
      exp_off_r   <= exp_off_nxt;
      exp_chunk_r <= exp_chunk_nxt;
      slots_r     <= slots_nxt;
      good_r      <= good_nxt;
      drop_r      <= drop_nxt;
      unr_r       <= unr_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    o_route_r <= o_route_nxt;
    o_off_r   <= o_off_nxt;
    o_tot_r   <= o_tot_nxt;
    o_last_r  <= o_last_nxt;
  end

  // counters only move on a pop, so they stand still while a result waits
  generate
    if (CB >= 32) begin : g_cnt_wide
      assign res.slot_count     = slots_r[31:0];
      assign res.good_frames    = good_r[31:0];
      assign res.dropped_frames = drop_r[31:0];
      assign res.unrouted_count = unr_r[31:0];
    end else begin : g_cnt_narrow
      assign res.slot_count     = {{(32-CB){1'b0}}, slots_r};
      assign res.good_frames    = {{(32-CB){1'b0}}, good_r};
      assign res.dropped_frames = {{(32-CB){1'b0}}, drop_r};
      assign res.unrouted_count = {{(32-CB){1'b0}}, unr_r};
    end
  endgenerate

  assign res.verdict      = verdict_r;
  assign res.route        = o_route_r;
  assign res.chunk_offset = o_off_r;
  assign res.chunk_total  = o_tot_r;
  assign res.last_chunk   = o_last_r;
  assign res_valid        = valid_r;

endmodule

// File: sv/chunked_frame_reassembly_checker_top.sv
// Chunked frame reassembly checker: one verdict per slot header, at one slot per clock cycle
// sustained. A slot accepted at the input is classified by the front end (header, payload, CRC
// and start checks against the configuration registers) and written into a two-entry queue; the
// back end takes it from the queue, checks it against the open frame, updates the frame state
// and the four wrapping counters, and loads the result register that drives the output. The
// queue and result register let input and output stall independently; rate drops below one
// per cycle only while out_tready is held low. Configuration writes are registered in the
// register bank and are meant for idle periods.
module chunked_frame_reassembly_checker_top #(
  parameter int COUNTER_BITS = cfrc_pkg::CNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cfrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // version_byte, flag_bits, declared_header_size, sequence_number, frame_size,
  // byte_offset, payload_length, chunk_number, slot_length, crc_match, file_busy,
  // stream_busy, zero pad
  input  logic [cfrc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // verdict, route, chunk_offset, chunk_total, slot_count, good_frames,
  // dropped_frames, unrouted_count, zero pad
  output logic [cfrc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  cfrc_pkg::cfg_t  cfg;
  cfrc_pkg::slot_t slot;
  cfrc_pkg::item_t f_item;
  cfrc_pkg::item_t q_item;
  cfrc_pkg::res_t  res;
  logic            q_valid;
  logic            q_ready;

  assign slot.version_byte         = in_tdata[7:0];
  assign slot.flag_bits            = in_tdata[15:8];
  assign slot.declared_header_size = in_tdata[31:16];
  assign slot.sequence_number      = in_tdata[63:32];
  assign slot.frame_size           = in_tdata[95:64];
  assign slot.byte_offset          = in_tdata[127:96];
  assign slot.payload_length       = in_tdata[143:128];
  assign slot.chunk_number         = in_tdata[159:144];
  assign slot.slot_length          = in_tdata[175:160];
  assign slot.crc_match            = in_tdata[176];
  assign slot.file_busy            = in_tdata[177];
  assign slot.stream_busy          = in_tdata[178];

  cfrc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cfrc_front u_front (
    .cfg  (cfg),
    .slot (slot),
    .item (f_item)
  );

  cfrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  cfrc_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.unrouted_count, res.dropped_frames, res.good_frames,
                      res.slot_count, res.chunk_total, res.chunk_offset, res.route,
                      res.verdict};
  assign out_tlast = res.last_chunk;

endmodule

// File: sv/cfrc_checker.sv
// port-level checker for the reassembly checker, bound to the top level
module cfrc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cfrc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  logic [3:0]  verdict;
  logic [1:0]  route;
  logic [31:0] off;
  logic [31:0] tot;

  assign verdict = out_tdata[3:0];
  assign route   = out_tdata[cfrc_pkg::OUT_ROUTE_LSB +: 2];
  assign off     = out_tdata[cfrc_pkg::OUT_OFF_LSB +: 32];
  assign tot     = out_tdata[cfrc_pkg::OUT_TOT_LSB +: 32];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict != cfrc_pkg::V_FORWARD |->
      route == cfrc_pkg::ROUTE_NONE && off == 32'd0 && tot == 32'd0 && !out_tlast)
    else $error("rejected slot carries forwarding fields");

  a_forward_routed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict == cfrc_pkg::V_FORWARD |->
      (route == cfrc_pkg::ROUTE_FILE || route == cfrc_pkg::ROUTE_STREAM) && tot != 32'd0)
    else $error("forwarded slot has no destination or empty frame");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> verdict <= cfrc_pkg::V_NO_END)
    else $error("verdict code out of range");

endmodule

bind chunked_frame_reassembly_checker_top cfrc_checker u_cfrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
